[src/ewsi_pkg.sv]
// Package for the energy window sorted insert block.
// Holds field widths, status codes, defaults and the broadcast struct.
// No dependencies.
`default_nettype none

package ewsi_pkg;

    // Field widths of the channels
    localparam int ENERGY_W  = 32;
    localparam int TAG_IN_W  = 16;
    localparam int CUTOFF_W  = 31;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 6;
    localparam int COUNT_W   = 7;
    localparam int TAG_MAX_W = 32;

    // Parameter defaults
    localparam int DEF_DEPTH    = 64;
    localparam int DEF_TAG_BITS = 16;

    // Cutoff after reset: 5.0 kcal/mol in units of 1/1024
    localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = CUTOFF_W'(5120);

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ACCEPT = 2'd0;
    localparam logic [STATUS_W-1:0] ST_HIGH   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    // Broadcast from the control to every cell of the chain
    typedef struct packed {
        logic                       upd;
        logic signed [ENERGY_W-1:0] energy;
        logic [TAG_MAX_W-1:0]       tag;
    } t_ewsi_bcast;

endpackage

`default_nettype wire

[src/ewsi_if.sv]
// Channel interfaces for the energy window sorted insert block.
// Depends on ewsi_pkg for field widths.
`default_nettype none

interface ewsi_in_if import ewsi_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [ENERGY_W-1:0] new_energy;
    logic [TAG_IN_W-1:0]        entry_tag;

    modport source (output valid, output new_energy, output entry_tag, input ready);
    modport sink   (input valid, input new_energy, input entry_tag, output ready);
endinterface

interface ewsi_out_if import ewsi_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output slot, output entry_count, input ready);
    modport sink   (input valid, input status, input slot, input entry_count, output ready);
endinterface

`default_nettype wire

[src/ewsi_cell.sv]
// One slot of the sorted table: energy key and tag.
// Loads from its lower neighbor on a shift or takes the new entry at the boundary.
// Depends on ewsi_pkg.
`default_nettype none

module ewsi_cell import ewsi_pkg::*; #(
    parameter int TAG_BITS = DEF_TAG_BITS
) (
    input  wire logic                       i_clk,
    input  wire t_ewsi_bcast                i_bc,
    input  wire logic                       i_occ,
    input  wire logic                       i_prev_take,
    input  wire logic signed [ENERGY_W-1:0] i_prev_energy,
    input  wire logic [TAG_BITS-1:0]        i_prev_tag,
    output logic                            o_take,
    output logic signed [ENERGY_W-1:0]      o_energy,
    output logic [TAG_BITS-1:0]             o_tag
);

    logic signed [ENERGY_W-1:0] r_energy;
    logic [TAG_BITS-1:0]        r_tag;

    // Slot is at or past the insert point: empty, or key strictly greater
    assign o_take   = !i_occ || (r_energy > i_bc.energy);
    assign o_energy = r_energy;
    assign o_tag    = r_tag;

    // Shift up from the neighbor, or take the new entry at the boundary
    always_ff @(posedge i_clk) begin
        if (i_bc.upd) begin
            if (i_prev_take) begin
                r_energy <= i_prev_energy;
                r_tag    <= i_prev_tag;
            end else if (o_take) begin
                r_energy <= i_bc.energy;
                r_tag    <= i_bc.tag[TAG_BITS-1:0];
            end
        end
    end

endmodule

`default_nettype wire

[src/energy_window_sorted_insert.sv]
// Top level of the energy window sorted insert block.
// Holds the item stage, fill count, cutoff register and the chain of cells.
// Depends on ewsi_pkg, ewsi_in_if, ewsi_out_if and ewsi_cell.
//
//  Channel   Dir  Payload                               Transfer
//  i_in      in   new_energy[31:0], entry_tag[15:0]     valid & ready
//  o_out     out  status[1:0], slot[5:0], entry_count   valid & ready
//  cfg       in   i_cfg_wdata[30:0] energy cutoff       i_cfg_we
//
// An item is taken into a holding stage and decided once o_out can take the result, when every
// cell compares its key in parallel and the chain shifts in one step.
// A new item is taken in the cycle its predecessor is decided, so one item per cycle
// is sustained while o_out is ready; the result is registered on the decide step and is held
// on o_out until it transfers.
// A result waiting on o_out stalls only the decide step; one item may queue behind it.
// Synchronous reset empties the table and restores the cutoff to 5120.
`default_nettype none

module energy_window_sorted_insert import ewsi_pkg::*; #(
    parameter int DEPTH    = DEF_DEPTH,
    parameter int TAG_BITS = DEF_TAG_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    ewsi_in_if.sink                  i_in,
    ewsi_out_if.source               o_out,
    input  wire logic                i_cfg_we,
    input  wire logic [CUTOFF_W-1:0] i_cfg_wdata
);

    localparam int SW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int KEEP = (TAG_BITS < TAG_IN_W) ? TAG_BITS : TAG_IN_W;

    logic [CUTOFF_W-1:0]        r_cutoff;
    logic                       r_busy;
    logic signed [ENERGY_W-1:0] r_energy;
    logic [TAG_BITS-1:0]        r_tag;
    logic [CW-1:0]              r_fill;
    logic                       r_ovalid;
    logic [STATUS_W-1:0]        r_status;
    logic [SW-1:0]              r_slot;

    logic                       eval_go;
    logic                       in_xfer;
    logic [STATUS_W-1:0]        n_status;
    logic [SW-1:0]              n_slot;
    logic signed [ENERGY_W:0]   diff;
    t_ewsi_bcast                bc;

    logic                       w_take  [DEPTH];
    logic                       w_ptake [DEPTH];
    logic signed [ENERGY_W-1:0] w_energy[DEPTH];
    logic [TAG_BITS-1:0]        w_tag   [DEPTH];

    assign eval_go    = r_busy && (!r_ovalid || o_out.ready);
    assign i_in.ready = !r_busy || eval_go;
    assign in_xfer    = i_in.valid && i_in.ready;

    // Hold the cutoff register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= CUTOFF_RESET;
        end else if (i_cfg_we) begin
            r_cutoff <= i_cfg_wdata;
        end
    end

    // Capture the offered item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (in_xfer) begin
            r_busy <= 1'b1;
        end else if (eval_go) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_energy <= i_in.new_energy;
            r_tag    <= TAG_BITS'(i_in.entry_tag[KEEP-1:0]);
        end
    end

    // Distance of the offer above the lowest stored key, exact in 33 bits
    assign diff = {r_energy[ENERGY_W-1], r_energy} - {w_energy[0][ENERGY_W-1], w_energy[0]};

    // Locate the boundary cell for the slot number
    always_comb begin
        n_slot = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (w_take[k] && !w_ptake[k]) begin
                n_slot = n_slot | SW'(k);
            end
        end
    end

    // Decide the status
    always_comb begin
        if (r_fill == '0) begin
            n_status = ST_ACCEPT;
        end else if (diff > $signed({2'b00, r_cutoff})) begin
            n_status = ST_HIGH;
        end else if (r_fill == CW'(DEPTH)) begin
            n_status = ST_FULL;
        end else begin
            n_status = ST_ACCEPT;
        end
    end

    assign bc.upd    = eval_go && (n_status == ST_ACCEPT);
    assign bc.energy = r_energy;
    assign bc.tag    = TAG_MAX_W'(r_tag);

    // Advance the fill count on an accepted insert
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (bc.upd) begin
            r_fill <= r_fill + CW'(1);
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (eval_go) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eval_go) begin
            r_status <= n_status;
            r_slot   <= (n_status == ST_ACCEPT) ? n_slot : '0;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.status      = r_status;
    assign o_out.slot        = SLOT_W'(r_slot);
    assign o_out.entry_count = COUNT_W'(r_fill);

    // Chain of table cells
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic                       occ;
        logic signed [ENERGY_W-1:0] prev_energy;
        logic [TAG_BITS-1:0]        prev_tag;

        assign occ = CW'(k) < r_fill;

        if (k == 0) begin : g_head
            assign w_ptake[k]  = 1'b0;
            assign prev_energy = r_energy;
            assign prev_tag    = r_tag;
        end else begin : g_body
            assign w_ptake[k]  = w_take[k-1];
            assign prev_energy = w_energy[k-1];
            assign prev_tag    = w_tag[k-1];
        end

        ewsi_cell #(
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_bc          (bc),
            .i_occ         (occ),
            .i_prev_take   (w_ptake[k]),
            .i_prev_energy (prev_energy),
            .i_prev_tag    (prev_tag),
            .o_take        (w_take[k]),
            .o_energy      (w_energy[k]),
            .o_tag         (w_tag[k])
        );
    end

    // Fill count never passes the table depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(DEPTH))
        else $error("fill count above depth");

    // An accepted decision grows the table by exactly one
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (eval_go && n_status == ST_ACCEPT) |=> (r_fill == $past(r_fill) + CW'(1)))
        else $error("fill count did not advance on insert");

    // Accepted slot lies within the entries present before the insert
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (eval_go && n_status == ST_ACCEPT) |-> (CW'(n_slot) <= r_fill))
        else $error("insert slot past fill count");

    // Lowest two stored keys stay in ascending order
    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill >= CW'(2)) |-> (w_energy[0] <= w_energy[1]))
        else $error("table head out of order");

endmodule

`default_nettype wire
